// ----- rtl/lgd_pkg.sv -----
// ----------------------------------------------------------------------------
// Label grid package
// Shared constants, codes and controller/datapath interface types.
// ----------------------------------------------------------------------------
package lgd_pkg;

   localparam int MAX_ROWS = 64;
   localparam int MAX_COLS = 64;
   localparam int ROW_W    = $clog2(MAX_ROWS);
   localparam int COL_W    = $clog2(MAX_COLS);
   localparam int ADDR_W   = ROW_W + COL_W;
   localparam int DEPTH    = MAX_ROWS * MAX_COLS;

   localparam int SIZE_W   = 7;
   localparam int SCALE_W  = 13;
   localparam int WORLD_W  = 19;
   localparam int NEAR_W   = 18;
   localparam int DIFF_W   = 21;
   localparam int SQ_W     = 41;
   localparam int DIV_STEPS = WORLD_W;
   localparam int DCNT_W   = $clog2(DIV_STEPS);

   localparam logic [7:0] UNCLAIMED = 8'hFF;

   localparam logic [1:0] MODE_CLEAR   = 2'd0;
   localparam logic [1:0] MODE_PAINT   = 2'd1;
   localparam logic [1:0] MODE_QUERY   = 2'd2;
   localparam logic [1:0] MODE_NEAREST = 2'd3;

   localparam logic [1:0] REG_GRID_X = 2'd0;
   localparam logic [1:0] REG_GRID_Y = 2'd1;
   localparam logic [1:0] REG_SCALE  = 2'd2;

   typedef struct packed {
      logic capture;
      logic sweep;
      logic paint_init;
      logic paint_step;
      logic div_init;
      logic div_step;
      logic div_sel_y;
      logic scan_init;
      logic scan_step;
      logic load_out;
   } cmd_type;

   typedef struct packed {
      logic sweep_last;
      logic paint_ok;
      logic paint_last;
      logic div_last;
      logic scan_empty;
      logic scan_last;
      logic pipe_busy;
   } status_type;

endpackage

// ----- rtl/label_grid_disc_paint_and_nearest_core.sv -----
// ----------------------------------------------------------------------------
// Label grid core
// Owner-label grid with clear, disc paint, cell query and nearest search.
// ----------------------------------------------------------------------------
//   Channel   Direction   Handshake              Carries
//   req_      in          req_valid/req_ready    mode, cell, radius, team, world
//   rsp_      out         rsp_valid/rsp_ready    label, valid, found, near point
//   csr_      in          csr_valid/csr_ready    register index and data
//
// Clear writes every memory cell, one memory cell a cycle. Paint visits each
// cell of the clipped brush square, up to (2*radius+1)^2. Query runs two
// 19-step divisions. Nearest visits rows*columns cells and then drains the
// scan pipeline. After reset, a clearing pass runs before the first request
// is taken. A new request is taken while a response still waits; the next
// response waits for the result register to empty.
module label_grid_disc_paint_and_nearest_core (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [1:0]                          req_mode,
   input  logic signed [7:0]                   req_cell_x,
   input  logic signed [7:0]                   req_cell_y,
   input  logic [5:0]                          req_radius,
   input  logic [7:0]                          req_team,
   input  logic signed [lgd_pkg::WORLD_W-1:0]  req_world_x,
   input  logic signed [lgd_pkg::WORLD_W-1:0]  req_world_y,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [7:0]                          rsp_label_out,
   output logic                                rsp_label_valid,
   output logic                                rsp_found,
   output logic [lgd_pkg::NEAR_W-1:0]          rsp_near_x,
   output logic [lgd_pkg::NEAR_W-1:0]          rsp_near_y,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [1:0]                          csr_index,
   input  logic [lgd_pkg::SCALE_W-1:0]         csr_data
);

   lgd_pkg::cmd_type    cmd;
   lgd_pkg::status_type sts;

   assign csr_ready = 1'b1;

   lgd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_mode  (req_mode),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .sts       (sts)
   );

   lgd_dp u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .sts             (sts),
      .csr_valid       (csr_valid),
      .csr_index       (csr_index),
      .csr_data        (csr_data),
      .req_mode        (req_mode),
      .req_cell_x      (req_cell_x),
      .req_cell_y      (req_cell_y),
      .req_radius      (req_radius),
      .req_team        (req_team),
      .req_world_x     (req_world_x),
      .req_world_y     (req_world_y),
      .rsp_label_out   (rsp_label_out),
      .rsp_label_valid (rsp_label_valid),
      .rsp_found       (rsp_found),
      .rsp_near_x      (rsp_near_x),
      .rsp_near_y      (rsp_near_y)
   );

endmodule

// ----- rtl/lgd_dp.sv -----
// ----------------------------------------------------------------------------
// Label grid datapath
// Label memory, configuration, paint walker, divider, scan pipeline, output.
// ----------------------------------------------------------------------------
module lgd_dp (
   input  logic                                clock,
   input  logic                                reset,
   input  lgd_pkg::cmd_type                    cmd,
   output lgd_pkg::status_type                 sts,
   input  logic                                csr_valid,
   input  logic [1:0]                          csr_index,
   input  logic [lgd_pkg::SCALE_W-1:0]         csr_data,
   input  logic [1:0]                          req_mode,
   input  logic signed [7:0]                   req_cell_x,
   input  logic signed [7:0]                   req_cell_y,
   input  logic [5:0]                          req_radius,
   input  logic [7:0]                          req_team,
   input  logic signed [lgd_pkg::WORLD_W-1:0]  req_world_x,
   input  logic signed [lgd_pkg::WORLD_W-1:0]  req_world_y,
   output logic [7:0]                          rsp_label_out,
   output logic                                rsp_label_valid,
   output logic                                rsp_found,
   output logic [lgd_pkg::NEAR_W-1:0]          rsp_near_x,
   output logic [lgd_pkg::NEAR_W-1:0]          rsp_near_y
);

   localparam int RW = lgd_pkg::ROW_W;
   localparam int CW = lgd_pkg::COL_W;
   localparam int AW = lgd_pkg::ADDR_W;
   localparam int WW = lgd_pkg::WORLD_W;
   localparam int DW = lgd_pkg::DIFF_W;
   localparam int QW = lgd_pkg::SQ_W;
   localparam int NW = lgd_pkg::NEAR_W;
   localparam int SW = lgd_pkg::SCALE_W;

   // Configuration.
   logic [lgd_pkg::SIZE_W-1:0] gx_ff, gy_ff, nr, nc;
   logic [SW-1:0]              sc_ff, sc_u;

   always_ff @(posedge clock) begin
      if (reset) begin
         gx_ff <= 7'd64;
         gy_ff <= 7'd64;
         sc_ff <= 13'd100;
      end else if (csr_valid) begin
         case (csr_index)
            lgd_pkg::REG_GRID_X: gx_ff <= csr_data[lgd_pkg::SIZE_W-1:0];
            lgd_pkg::REG_GRID_Y: gy_ff <= csr_data[lgd_pkg::SIZE_W-1:0];
            lgd_pkg::REG_SCALE:  sc_ff <= csr_data;
            default: ;
         endcase
      end
   end

   assign nr   = (gx_ff > 7'(lgd_pkg::MAX_ROWS)) ? 7'(lgd_pkg::MAX_ROWS) : gx_ff;
   assign nc   = (gy_ff > 7'(lgd_pkg::MAX_COLS)) ? 7'(lgd_pkg::MAX_COLS) : gy_ff;
   assign sc_u = (sc_ff == '0) ? SW'(1) : sc_ff;

   // Captured request.
   logic [1:0]           mode_ff;
   logic signed [7:0]    cx_ff, cy_ff;
   logic [5:0]           r_ff;
   logic [7:0]           team_ff;
   logic signed [WW-1:0] wx_ff, wy_ff;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         mode_ff <= req_mode;
         cx_ff   <= req_cell_x;
         cy_ff   <= req_cell_y;
         r_ff    <= req_radius;
         team_ff <= req_team;
         wx_ff   <= req_world_x;
         wy_ff   <= req_world_y;
      end
   end

   // Label memory.
   logic [7:0]    grid_mem [lgd_pkg::DEPTH];
   logic          mem_we;
   logic [AW-1:0] mem_waddr, mem_raddr;
   logic [7:0]    mem_wdata, rdata_ff;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         grid_mem[mem_waddr] <= mem_wdata;
      end
      rdata_ff <= grid_mem[mem_raddr];
   end

   // Clear sweep.
   logic [AW-1:0] sw_ff;

   always_ff @(posedge clock) begin
      if (reset || cmd.capture) begin
         sw_ff <= '0;
      end else if (cmd.sweep) begin
         sw_ff <= sw_ff + AW'(1);
      end
   end

   assign sts.sweep_last = (sw_ff == '1);

   // Paint walker.
   logic signed [9:0]  cx_e, cy_e, r_e, nr_e, nc_e, ilo, ihi, jlo, jhi, pdx, pdy;
   logic [RW-1:0]      pi_ff, phi_i_ff;
   logic [CW-1:0]      pj_ff, plo_j_ff, phi_j_ff;
   logic [19:0]        dsq, rsq;
   logic               in_disc;

   assign cx_e = 10'(cx_ff);
   assign cy_e = 10'(cy_ff);
   assign r_e  = signed'({4'b0, r_ff});
   assign nr_e = signed'({3'b0, nr});
   assign nc_e = signed'({3'b0, nc});
   assign ilo  = (cx_e - r_e < 0) ? 10'sd0 : cx_e - r_e;
   assign ihi  = (cx_e + r_e > nr_e - 10'sd1) ? nr_e - 10'sd1 : cx_e + r_e;
   assign jlo  = (cy_e - r_e < 0) ? 10'sd0 : cy_e - r_e;
   assign jhi  = (cy_e + r_e > nc_e - 10'sd1) ? nc_e - 10'sd1 : cy_e + r_e;

   assign sts.paint_ok = (cx_e >= 0) && (cx_e < nr_e) && (cy_e >= 0) && (cy_e < nc_e);

   always_ff @(posedge clock) begin
      if (cmd.paint_init) begin
         pi_ff    <= ilo[RW-1:0];
         pj_ff    <= jlo[CW-1:0];
         plo_j_ff <= jlo[CW-1:0];
         phi_i_ff <= ihi[RW-1:0];
         phi_j_ff <= jhi[CW-1:0];
      end else if (cmd.paint_step) begin
         if (pj_ff == phi_j_ff) begin
            pj_ff <= plo_j_ff;
            pi_ff <= pi_ff + RW'(1);
         end else begin
            pj_ff <= pj_ff + CW'(1);
         end
      end
   end

   assign pdx     = signed'(10'(pi_ff)) - cx_e;
   assign pdy     = signed'(10'(pj_ff)) - cy_e;
   assign dsq     = 20'(20'(pdx) * 20'(pdx)) + 20'(20'(pdy) * 20'(pdy));
   assign rsq     = 20'(r_ff) * 20'(r_ff);
   assign in_disc = (dsq <= rsq);
   assign sts.paint_last = (pi_ff == phi_i_ff) && (pj_ff == phi_j_ff);

   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = {pi_ff, pj_ff};
      mem_wdata = team_ff;
      if (cmd.sweep) begin
         mem_we    = 1'b1;
         mem_waddr = sw_ff;
         mem_wdata = lgd_pkg::UNCLAIMED;
      end else if (cmd.paint_step && in_disc) begin
         mem_we = 1'b1;
      end
   end

   // Restoring divider for the query cell.
   logic signed [WW-1:0] wsel;
   logic [WW-1:0]        dq_ff, dq_in, qmag;
   logic [SW-1:0]        rem_ff;
   logic [SW:0]          trial;
   logic                 ge, neg_ff, q_ok;
   logic [lgd_pkg::DCNT_W-1:0] dcnt_ff;
   logic [RW-1:0]        qrow_ff;
   logic [CW-1:0]        qcol_ff;
   logic                 qx_ok_ff, qy_ok_ff;

   assign wsel  = cmd.div_sel_y ? wy_ff : wx_ff;
   assign trial = {rem_ff, dq_ff[WW-1]};
   assign ge    = (trial >= {1'b0, sc_u});
   assign dq_in = {dq_ff[WW-2:0], ge};
   assign qmag  = dq_in;
   assign q_ok  = (!neg_ff || (qmag == '0)) &&
                  (qmag < WW'(cmd.div_sel_y ? nc : nr));
   assign sts.div_last = (dcnt_ff == lgd_pkg::DCNT_W'(lgd_pkg::DIV_STEPS - 1));

   always_ff @(posedge clock) begin
      if (cmd.div_init) begin
         dq_ff   <= wsel[WW-1] ? WW'(-wsel) : WW'(wsel);
         neg_ff  <= wsel[WW-1];
         rem_ff  <= '0;
         dcnt_ff <= '0;
      end else if (cmd.div_step) begin
         dq_ff   <= dq_in;
         rem_ff  <= ge ? SW'(trial - {1'b0, sc_u}) : trial[SW-1:0];
         dcnt_ff <= dcnt_ff + lgd_pkg::DCNT_W'(1);
         if (sts.div_last) begin
            if (cmd.div_sel_y) begin
               qcol_ff  <= qmag[CW-1:0];
               qy_ok_ff <= q_ok;
            end else begin
               qrow_ff  <= qmag[RW-1:0];
               qx_ok_ff <= q_ok;
            end
         end
      end
   end

   // Nearest scan pipeline.
   logic [RW-1:0]   si_ff;
   logic [CW-1:0]   sj_ff;
   logic [WW-1:0]   row_w_ff, col_w_ff;
   logic            p1_v_ff, p2_v_ff, p3_v_ff;
   logic [WW-1:0]   p1_rw_ff, p1_cw_ff, p2_rw_ff, p2_cw_ff, p3_rw_ff, p3_cw_ff;
   logic            p2_m_ff, p3_m_ff;
   logic signed [DW-1:0] p2_dx_ff, p2_dy_ff;
   logic [QW-1:0]   p3_sx_ff, p3_sy_ff, sq_sum;
   logic signed [2*DW-1:0] prod_x, prod_y;
   logic            have_ff;
   logic [QW-1:0]   best_ff;
   logic [NW-1:0]   bx_ff, by_ff;

   assign sts.scan_empty = (nr == '0) || (nc == '0);
   assign sts.scan_last  = (7'(si_ff) == nr - 7'd1) && (7'(sj_ff) == nc - 7'd1);
   assign sts.pipe_busy  = p1_v_ff || p2_v_ff || p3_v_ff;

   assign mem_raddr = (mode_ff == lgd_pkg::MODE_QUERY) ? {qrow_ff, qcol_ff} : {si_ff, sj_ff};

   always_ff @(posedge clock) begin
      if (cmd.scan_init) begin
         si_ff    <= '0;
         sj_ff    <= '0;
         row_w_ff <= '0;
         col_w_ff <= '0;
      end else if (cmd.scan_step) begin
         if (7'(sj_ff) == nc - 7'd1) begin
            sj_ff    <= '0;
            col_w_ff <= '0;
            si_ff    <= si_ff + RW'(1);
            row_w_ff <= row_w_ff + WW'(sc_u);
         end else begin
            sj_ff    <= sj_ff + CW'(1);
            col_w_ff <= col_w_ff + WW'(sc_u);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_v_ff <= 1'b0;
         p2_v_ff <= 1'b0;
         p3_v_ff <= 1'b0;
      end else begin
         p1_v_ff <= cmd.scan_step;
         p2_v_ff <= p1_v_ff;
         p3_v_ff <= p2_v_ff;
      end
   end

   assign prod_x = p2_dx_ff * p2_dx_ff;
   assign prod_y = p2_dy_ff * p2_dy_ff;
   assign sq_sum = p3_sx_ff + p3_sy_ff;

   always_ff @(posedge clock) begin
      p1_rw_ff <= row_w_ff;
      p1_cw_ff <= col_w_ff;
      p2_m_ff  <= (rdata_ff == team_ff);
      p2_dx_ff <= DW'(wx_ff) - signed'(DW'(p1_rw_ff));
      p2_dy_ff <= DW'(wy_ff) - signed'(DW'(p1_cw_ff));
      p2_rw_ff <= p1_rw_ff;
      p2_cw_ff <= p1_cw_ff;
      p3_m_ff  <= p2_m_ff;
      p3_sx_ff <= prod_x[QW-1:0];
      p3_sy_ff <= prod_y[QW-1:0];
      p3_rw_ff <= p2_rw_ff;
      p3_cw_ff <= p2_cw_ff;
   end

   always_ff @(posedge clock) begin
      if (cmd.scan_init) begin
         have_ff <= 1'b0;
         best_ff <= '0;
         bx_ff   <= '0;
         by_ff   <= '0;
      end else if (p3_v_ff && p3_m_ff && (!have_ff || (sq_sum < best_ff))) begin
         have_ff <= 1'b1;
         best_ff <= sq_sum;
         bx_ff   <= p3_rw_ff[NW-1:0];
         by_ff   <= p3_cw_ff[NW-1:0];
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         rsp_label_out   <= '0;
         rsp_label_valid <= 1'b0;
         rsp_found       <= 1'b0;
         rsp_near_x      <= '0;
         rsp_near_y      <= '0;
         case (mode_ff)
            lgd_pkg::MODE_QUERY: begin
               rsp_label_out   <= (qx_ok_ff && qy_ok_ff) ? rdata_ff : 8'd0;
               rsp_label_valid <= qx_ok_ff && qy_ok_ff;
            end
            lgd_pkg::MODE_NEAREST: begin
               rsp_found  <= have_ff;
               rsp_near_x <= have_ff ? bx_ff : '0;
               rsp_near_y <= have_ff ? by_ff : '0;
            end
            default: ;
         endcase
      end
   end

endmodule

// ----- rtl/lgd_ctrl.sv -----
// ----------------------------------------------------------------------------
// Label grid controller
// Sequences each request through the datapath and owns the request and response handshakes.
// ----------------------------------------------------------------------------
module lgd_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [1:0]          req_mode,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output lgd_pkg::cmd_type    cmd,
   input  lgd_pkg::status_type sts
);

   typedef enum logic [3:0] {
      S_BOOT, S_IDLE, S_CLR, S_PAINT_INIT, S_PAINT, S_QX_INIT, S_QX,
      S_QY_INIT, S_QY, S_QREAD, S_SCAN_INIT, S_SCAN, S_DRAIN, S_DONE
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      accept, out_free;

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   always_comb begin
      cmd          = '0;
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         S_BOOT: begin
            cmd.sweep = 1'b1;
            if (sts.sweep_last) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (accept) begin
               cmd.capture = 1'b1;
               case (req_mode)
                  lgd_pkg::MODE_CLEAR: state_in = S_CLR;
                  lgd_pkg::MODE_PAINT: state_in = S_PAINT_INIT;
                  lgd_pkg::MODE_QUERY: state_in = S_QX_INIT;
                  default:             state_in = S_SCAN_INIT;
               endcase
            end
         end
         S_CLR: begin
            cmd.sweep = 1'b1;
            if (sts.sweep_last) state_in = S_DONE;
         end
         S_PAINT_INIT: begin
            cmd.paint_init = 1'b1;
            state_in = sts.paint_ok ? S_PAINT : S_DONE;
         end
         S_PAINT: begin
            cmd.paint_step = 1'b1;
            if (sts.paint_last) state_in = S_DONE;
         end
         S_QX_INIT: begin
            cmd.div_init = 1'b1;
            state_in = S_QX;
         end
         S_QX: begin
            cmd.div_step = 1'b1;
            if (sts.div_last) state_in = S_QY_INIT;
         end
         S_QY_INIT: begin
            cmd.div_init  = 1'b1;
            cmd.div_sel_y = 1'b1;
            state_in = S_QY;
         end
         S_QY: begin
            cmd.div_step  = 1'b1;
            cmd.div_sel_y = 1'b1;
            if (sts.div_last) state_in = S_QREAD;
         end
         S_QREAD: begin
            state_in = S_DONE;
         end
         S_SCAN_INIT: begin
            cmd.scan_init = 1'b1;
            state_in = sts.scan_empty ? S_DONE : S_SCAN;
         end
         S_SCAN: begin
            cmd.scan_step = 1'b1;
            if (sts.scan_last) state_in = S_DRAIN;
         end
         S_DRAIN: begin
            if (!sts.pipe_busy) state_in = S_DONE;
         end
         S_DONE: begin
            if (out_free) begin
               cmd.load_out = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_BOOT;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule
